[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vnac_pkg.sv]
// ----------------------------------------------------------------------------
// vnac_pkg
// Types and constants shared by the vertex normal accumulator modules.
// ----------------------------------------------------------------------------
package vnac_pkg;

  localparam int ID_W   = 11;  // vertex id on the ports
  localparam int IDX_W  = 16;  // zero-based table index, wide enough for any depth
  localparam int POS_W  = 24;  // Q12.12 position component
  localparam int SUM_W  = 24;  // saturating normal sum component
  localparam int NRM_W  = 16;  // Q1.15 normal component
  localparam int DIF_W  = 25;  // edge vector component
  localparam int PRD_W  = 50;  // edge component product
  localparam int VEC_W  = 51;  // cross product component
  localparam int MAX_VERTICES_DEF = 1024;

  // Item kinds as they arrive on the func field.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_STORE = 2'd1,
    OP_TRI   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic KIND_FACE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // One classified command travelling from the front to the back.
  typedef struct packed {
    op_t                     op;
    logic [ID_W-1:0]         id_a;
    logic [IDX_W-1:0]        idx_a;
    logic [IDX_W-1:0]        idx_b;
    logic [IDX_W-1:0]        idx_c;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_CLEAR,
    BK_PRD,
    BK_CROSS,
    BK_SRD,
    BK_NSTART,
    BK_NWAIT,
    BK_SUM,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [2:0] {
    NM_IDLE,
    NM_MAX,
    NM_SHIFT,
    NM_SQ,
    NM_SQRT,
    NM_DIV,
    NM_DONE
  } nm_state_t;

endpackage

[sv/vnac_ram.sv]
// ----------------------------------------------------------------------------
// vnac_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vnac_ram #(
  parameter int W     = 72,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/vnac_norm.sv]
// ----------------------------------------------------------------------------
// vnac_norm
// Iterative vector normalizer: block scaling, sum of squares, bit-serial
// square root and a restoring divider producing Q1.15 components.
// ----------------------------------------------------------------------------
module vnac_norm (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [vnac_pkg::VEC_W-1:0]   vec_x,
  input  logic signed [vnac_pkg::VEC_W-1:0]   vec_y,
  input  logic signed [vnac_pkg::VEC_W-1:0]   vec_z,
  output logic                                done,
  output logic signed [vnac_pkg::NRM_W-1:0]   nrm_x,
  output logic signed [vnac_pkg::NRM_W-1:0]   nrm_y,
  output logic signed [vnac_pkg::NRM_W-1:0]   nrm_z
);

  vnac_pkg::nm_state_t st_r, st_nxt;

  logic [vnac_pkg::VEC_W-1:0]        mag_r [3];
  logic                              neg_r [3];
  logic [vnac_pkg::VEC_W-1:0]        m_r;
  logic [4:0]                        cnt_r;
  logic [1:0]                        comp_r;
  logic [59:0]                       prod_r;
  logic [61:0]                       sq_r;
  logic [61:0]                       sq_sum;
  logic [62:0]                       n_r;
  logic [62:0]                       res_r;
  logic [62:0]                       bit_r;
  logic [62:0]                       rt_try;
  logic [30:0]                       len_r;
  logic [30:0]                       rem_r;
  logic [16:0]                       lo_r;
  logic [16:0]                       q_r;
  logic [45:0]                       num;
  logic [31:0]                       dv_t;
  logic [31:0]                       dv_diff;
  logic                              dv_ge;
  logic [16:0]                       q_fin;
  logic [15:0]                       q_sat;
  logic [vnac_pkg::VEC_W-1:0]        m01;
  logic signed [vnac_pkg::NRM_W-1:0] nrm_r [3];

  // Datapath helpers. The root stays in res_r for the whole divide phase.
  always_comb begin
    sq_sum  = sq_r + {2'b00, prod_r};
    rt_try  = res_r + bit_r;
    num     = {1'b0, mag_r[comp_r][29:0], 15'd0} + {16'd0, res_r[30:1]};
    dv_t    = {rem_r, lo_r[16]};
    dv_diff = dv_t - {1'b0, len_r};
    dv_ge   = (dv_t >= {1'b0, len_r});
    q_fin   = {q_r[15:0], dv_ge};
    q_sat   = (q_fin[16] || q_fin[15]) ? 16'h7FFF : q_fin[15:0];
    m01     = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= vnac_pkg::NM_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Next state and done strobe.
  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    case (st_r)
      vnac_pkg::NM_IDLE: begin
        if (start) st_nxt = vnac_pkg::NM_MAX;
      end
      vnac_pkg::NM_MAX: begin
        if (m01 == '0 && mag_r[2] == '0) st_nxt = vnac_pkg::NM_DONE;
        else st_nxt = vnac_pkg::NM_SHIFT;
      end
      vnac_pkg::NM_SHIFT: begin
        if (m_r[vnac_pkg::VEC_W-1:30] == '0 && m_r[29]) st_nxt = vnac_pkg::NM_SQ;
      end
      vnac_pkg::NM_SQ: begin
        if (cnt_r == 5'd3) st_nxt = vnac_pkg::NM_SQRT;
      end
      vnac_pkg::NM_SQRT: begin
        if (bit_r[0]) st_nxt = vnac_pkg::NM_DIV;
      end
      vnac_pkg::NM_DIV: begin
        if (cnt_r == 5'd17 && comp_r == 2'd2) st_nxt = vnac_pkg::NM_DONE;
      end
      vnac_pkg::NM_DONE: begin
        done   = 1'b1;
        st_nxt = vnac_pkg::NM_IDLE;
      end
      default: st_nxt = vnac_pkg::NM_IDLE;
    endcase
  end

  // Datapath registers, one step per cycle.
  always_ff @(posedge clk) begin
    case (st_r)
      vnac_pkg::NM_IDLE: begin
        if (start) begin
          neg_r[0] <= vec_x[vnac_pkg::VEC_W-1];
          neg_r[1] <= vec_y[vnac_pkg::VEC_W-1];
          neg_r[2] <= vec_z[vnac_pkg::VEC_W-1];
          mag_r[0] <= vec_x[vnac_pkg::VEC_W-1] ? vnac_pkg::VEC_W'(-vec_x) : vec_x;
          mag_r[1] <= vec_y[vnac_pkg::VEC_W-1] ? vnac_pkg::VEC_W'(-vec_y) : vec_y;
          mag_r[2] <= vec_z[vnac_pkg::VEC_W-1] ? vnac_pkg::VEC_W'(-vec_z) : vec_z;
        end
      end
      vnac_pkg::NM_MAX: begin
        m_r <= (m01 > mag_r[2]) ? m01 : mag_r[2];
        for (int i = 0; i < 3; i++) nrm_r[i] <= '0;
      end
      vnac_pkg::NM_SHIFT: begin
        // Bring the largest magnitude into [2^29, 2^30) one bit a cycle.
        if (m_r[vnac_pkg::VEC_W-1:30] != '0) begin
          m_r <= m_r >> 1;
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end else if (!m_r[29]) begin
          m_r <= m_r << 1;
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
        end
        cnt_r  <= '0;
        prod_r <= '0;
        sq_r   <= '0;
      end
      vnac_pkg::NM_SQ: begin
        // One square per cycle, registered in prod_r and then accumulated into sq_r.
        if (cnt_r != 5'd3) begin
          prod_r <= mag_r[cnt_r[1:0]][29:0] * mag_r[cnt_r[1:0]][29:0];
        end
        sq_r  <= sq_sum;
        cnt_r <= cnt_r + 5'd1;
        n_r   <= {1'b0, sq_sum};
        res_r <= '0;
        bit_r <= {1'b1, 62'd0};
      end
      vnac_pkg::NM_SQRT: begin
        // Bit-serial integer square root, one result bit per cycle.
        if (n_r >= rt_try) begin
          n_r   <= n_r - rt_try;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        cnt_r  <= '0;
        comp_r <= '0;
      end
      vnac_pkg::NM_DIV: begin
        if (cnt_r == 5'd0) begin
          if (comp_r == 2'd0) len_r <= res_r[30:0];
          cnt_r <= 5'd1;
        end else begin
          cnt_r <= (cnt_r == 5'd17) ? 5'd0 : cnt_r + 5'd1;
          if (cnt_r == 5'd17) begin
            nrm_r[comp_r] <= neg_r[comp_r] ? -$signed(q_sat) : $signed(q_sat);
            comp_r        <= comp_r + 2'd1;
          end
        end
        // Restoring division, one quotient bit per cycle.
        if (cnt_r == 5'd0) begin
          q_r <= '0;
        end else begin
          rem_r <= dv_ge ? dv_diff[30:0] : dv_t[30:0];
          lo_r  <= lo_r << 1;
          q_r   <= q_fin;
        end
      end
      default: begin
      end
    endcase
    // Dividend load at the start of each component.
    if (st_r == vnac_pkg::NM_DIV && cnt_r == 5'd0) begin
      rem_r <= {2'b00, num[45:17]};
      lo_r  <= num[16:0];
    end
  end

  assign nrm_x = nrm_r[0];
  assign nrm_y = nrm_r[1];
  assign nrm_z = nrm_r[2];

endmodule

[sv/vnac_front.sv]
// ----------------------------------------------------------------------------
// vnac_front
// Input side: checks vertex ids, drops items with bad ids and queues the
// remaining commands for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module vnac_front #(
  parameter int MAX_VERTICES = vnac_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [1:0]                          in_func,
  input  logic [vnac_pkg::ID_W-1:0]           in_vertex_a,
  input  logic [vnac_pkg::ID_W-1:0]           in_vertex_b,
  input  logic [vnac_pkg::ID_W-1:0]           in_vertex_c,
  input  logic signed [vnac_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [vnac_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [vnac_pkg::POS_W-1:0]   in_pos_z,
  input  logic                                init_busy,
  output logic                                q_valid,
  output vnac_pkg::cmd_t                      q_data,
  input  logic                                q_pop
);

  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);

  vnac_pkg::cmd_t q_mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           accept;
  logic           keep;
  logic           push_q;
  vnac_pkg::cmd_t cmd;

  function automatic logic id_ok(input logic [vnac_pkg::ID_W-1:0] id);
    return (id != '0) && ({6'd0, id} <= MAXV);
  endfunction

  function automatic logic [vnac_pkg::IDX_W-1:0] to_idx(input logic [vnac_pkg::ID_W-1:0] id);
    logic [16:0] t;
    t = {6'd0, id} - 17'd1;
    return t[vnac_pkg::IDX_W-1:0];
  endfunction

  // Classify the incoming beat.
  always_comb begin
    cmd.op    = vnac_pkg::op_t'(in_func);
    cmd.id_a  = in_vertex_a;
    cmd.idx_a = to_idx(in_vertex_a);
    cmd.idx_b = to_idx(in_vertex_b);
    cmd.idx_c = to_idx(in_vertex_c);
    cmd.pos_x = in_pos_x;
    cmd.pos_y = in_pos_y;
    cmd.pos_z = in_pos_z;
    case (cmd.op)
      vnac_pkg::OP_CLEAR: keep = 1'b1;
      vnac_pkg::OP_STORE: keep = id_ok(in_vertex_a);
      vnac_pkg::OP_READ:  keep = id_ok(in_vertex_a);
      vnac_pkg::OP_TRI:   keep = id_ok(in_vertex_a) && id_ok(in_vertex_b) &&
                                 id_ok(in_vertex_c);
      default:            keep = 1'b0;
    endcase
  end

  assign in_full = (cnt_r == 2'd2) || init_busy;
  assign accept  = in_push && !in_full;
  assign push_q  = accept && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = q_mem_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_q) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push_q && !q_pop) cnt_r <= cnt_r + 2'd1;
      else if (!push_q && q_pop) cnt_r <= cnt_r - 2'd1;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push_q) q_mem_r[wr_ptr_r] <= cmd;
  end

endmodule

[sv/vnac_back.sv]
// ----------------------------------------------------------------------------
// vnac_back
// Execution side: position and sum tables, cross product, normalizer,
// saturating sum updates, clearing sweeps and the result register.
// ----------------------------------------------------------------------------
module vnac_back #(
  parameter int MAX_VERTICES = vnac_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  vnac_pkg::cmd_t                      q_data,
  output logic                                q_pop,
  output logic                                init_busy,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic                                out_kind,
  output logic [vnac_pkg::ID_W-1:0]           out_vertex_id,
  output logic signed [vnac_pkg::NRM_W-1:0]   out_norm_x,
  output logic signed [vnac_pkg::NRM_W-1:0]   out_norm_y,
  output logic signed [vnac_pkg::NRM_W-1:0]   out_norm_z
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [AW-1:0] LAST = AW'(MAX_VERTICES - 1);
  localparam int RW = 3 * vnac_pkg::POS_W;

  vnac_pkg::bk_state_t st_r, st_nxt;

  vnac_pkg::cmd_t                    cmd_r;
  logic [1:0]                        k_r;
  logic                              ph_r;
  logic [AW-1:0]                     clr_r;
  logic                              out_valid_r;
  logic signed [vnac_pkg::POS_W-1:0] pa_r [3];
  logic signed [vnac_pkg::POS_W-1:0] pb_r [3];
  logic signed [vnac_pkg::DIF_W-1:0] da_r [3];
  logic signed [vnac_pkg::DIF_W-1:0] db_r [3];
  logic signed [vnac_pkg::PRD_W-1:0] p1_r;
  logic signed [vnac_pkg::PRD_W-1:0] p2_r;
  logic signed [vnac_pkg::VEC_W-1:0] vec_r [3];
  logic signed [vnac_pkg::NRM_W-1:0] nrm_r [3];

  logic [AW-1:0]                     sel_idx;
  logic                              pos_we;
  logic [RW-1:0]                     pos_rdata;
  logic                              sum_we;
  logic [AW-1:0]                     sum_waddr;
  logic [RW-1:0]                     sum_wdata;
  logic [RW-1:0]                     sum_rdata;
  logic signed [vnac_pkg::POS_W-1:0] rd_pos [3];
  logic signed [vnac_pkg::SUM_W-1:0] rd_sum [3];
  logic [1:0]                        i1;
  logic [1:0]                        i2;
  logic                              slot_free;
  logic                              norm_start;
  logic                              norm_done;
  logic signed [vnac_pkg::NRM_W-1:0] n_x, n_y, n_z;

  // Add a face normal component to a sum, clamping to the 24-bit range.
  function automatic logic signed [vnac_pkg::SUM_W-1:0] sat_add(
    input logic signed [vnac_pkg::SUM_W-1:0] s,
    input logic signed [vnac_pkg::NRM_W-1:0] n
  );
    logic signed [vnac_pkg::SUM_W:0] t;
    t = {s[vnac_pkg::SUM_W-1], s} + {{(vnac_pkg::SUM_W-vnac_pkg::NRM_W+1){n[vnac_pkg::NRM_W-1]}}, n};
    if (t[vnac_pkg::SUM_W] != t[vnac_pkg::SUM_W-1]) begin
      return t[vnac_pkg::SUM_W] ? {1'b1, {(vnac_pkg::SUM_W-1){1'b0}}}
                                : {1'b0, {(vnac_pkg::SUM_W-1){1'b1}}};
    end
    return t[vnac_pkg::SUM_W-1:0];
  endfunction

  // Unpack table words, pick the corner index and cross-product operands, build the sum word.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_pos[i] = pos_rdata[RW-1-vnac_pkg::POS_W*i -: vnac_pkg::POS_W];
      rd_sum[i] = sum_rdata[RW-1-vnac_pkg::SUM_W*i -: vnac_pkg::SUM_W];
    end
    case (k_r)
      2'd0:    sel_idx = cmd_r.idx_a[AW-1:0];
      2'd1:    sel_idx = cmd_r.idx_b[AW-1:0];
      default: sel_idx = cmd_r.idx_c[AW-1:0];
    endcase
    case (k_r)
      2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
      2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
    for (int i = 0; i < 3; i++) begin
      sum_wdata[RW-1-vnac_pkg::SUM_W*i -: vnac_pkg::SUM_W] =
        (st_r == vnac_pkg::BK_SUM) ? sat_add(rd_sum[i], nrm_r[i]) : '0;
    end
  end

  assign init_busy = (st_r == vnac_pkg::BK_INIT);
  assign slot_free = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign pos_we    = (st_r == vnac_pkg::BK_IDLE) && q_valid &&
                     (q_data.op == vnac_pkg::OP_STORE);
  assign sum_we    = (st_r == vnac_pkg::BK_INIT) || (st_r == vnac_pkg::BK_CLEAR) ||
                     ((st_r == vnac_pkg::BK_SUM) && ph_r);
  assign sum_waddr = (st_r == vnac_pkg::BK_SUM) ? sel_idx : clr_r;

  vnac_ram #(.W(RW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (q_data.idx_a[AW-1:0]),
    .wdata ({q_data.pos_x, q_data.pos_y, q_data.pos_z}),
    .raddr (sel_idx),
    .rdata (pos_rdata)
  );

  vnac_ram #(.W(RW), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sel_idx),
    .rdata (sum_rdata)
  );

  vnac_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vec_x (vec_r[0]),
    .vec_y (vec_r[1]),
    .vec_z (vec_r[2]),
    .done  (norm_done),
    .nrm_x (n_x),
    .nrm_y (n_y),
    .nrm_z (n_z)
  );

  // Sequencer next state and strobes.
  always_comb begin
    st_nxt     = st_r;
    q_pop      = 1'b0;
    norm_start = 1'b0;
    case (st_r)
      vnac_pkg::BK_INIT, vnac_pkg::BK_CLEAR: begin
        if (clr_r == LAST) st_nxt = vnac_pkg::BK_IDLE;
      end
      vnac_pkg::BK_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          case (q_data.op)
            vnac_pkg::OP_CLEAR: st_nxt = vnac_pkg::BK_CLEAR;
            vnac_pkg::OP_TRI:   st_nxt = vnac_pkg::BK_PRD;
            vnac_pkg::OP_READ:  st_nxt = vnac_pkg::BK_SRD;
            default:            st_nxt = vnac_pkg::BK_IDLE;
          endcase
        end
      end
      vnac_pkg::BK_PRD: begin
        if (k_r == 2'd3) st_nxt = vnac_pkg::BK_CROSS;
      end
      vnac_pkg::BK_CROSS: begin
        if (k_r == 2'd3) st_nxt = vnac_pkg::BK_NSTART;
      end
      vnac_pkg::BK_SRD: begin
        if (k_r == 2'd1) st_nxt = vnac_pkg::BK_NSTART;
      end
      vnac_pkg::BK_NSTART: begin
        norm_start = 1'b1;
        st_nxt     = vnac_pkg::BK_NWAIT;
      end
      vnac_pkg::BK_NWAIT: begin
        if (norm_done) begin
          st_nxt = (cmd_r.op == vnac_pkg::OP_TRI) ? vnac_pkg::BK_SUM : vnac_pkg::BK_EMIT;
        end
      end
      vnac_pkg::BK_SUM: begin
        if (ph_r && k_r == 2'd2) st_nxt = vnac_pkg::BK_EMIT;
      end
      vnac_pkg::BK_EMIT: begin
        if (slot_free) st_nxt = vnac_pkg::BK_IDLE;
      end
      default: st_nxt = vnac_pkg::BK_IDLE;
    endcase
  end

  // State register and control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= vnac_pkg::BK_INIT;
      clr_r       <= '0;
      k_r         <= 2'd0;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        vnac_pkg::BK_INIT, vnac_pkg::BK_CLEAR: begin
          clr_r <= (clr_r == LAST) ? '0 : clr_r + 1'b1;
        end
        vnac_pkg::BK_IDLE: begin
          k_r  <= 2'd0;
          ph_r <= 1'b0;
        end
        vnac_pkg::BK_PRD, vnac_pkg::BK_CROSS, vnac_pkg::BK_SRD: begin
          k_r <= k_r + 2'd1;
        end
        vnac_pkg::BK_NWAIT: begin
          k_r  <= 2'd0;
          ph_r <= 1'b0;
        end
        vnac_pkg::BK_SUM: begin
          ph_r <= ~ph_r;
          if (ph_r) k_r <= k_r + 2'd1;
        end
        default: begin
        end
      endcase
      if (st_r == vnac_pkg::BK_EMIT && slot_free) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (st_r)
      vnac_pkg::BK_IDLE: begin
        if (q_valid) cmd_r <= q_data;
      end
      vnac_pkg::BK_PRD: begin
        // Corner positions arrive in the cycle after their read, from the registered RAM read.
        for (int i = 0; i < 3; i++) begin
          if (k_r == 2'd1) pa_r[i] <= rd_pos[i];
          if (k_r == 2'd2) pb_r[i] <= rd_pos[i];
          if (k_r == 2'd3) begin
            da_r[i] <= {pa_r[i][vnac_pkg::POS_W-1], pa_r[i]} -
                       {pb_r[i][vnac_pkg::POS_W-1], pb_r[i]};
            db_r[i] <= {pb_r[i][vnac_pkg::POS_W-1], pb_r[i]} -
                       {rd_pos[i][vnac_pkg::POS_W-1], rd_pos[i]};
          end
        end
      end
      vnac_pkg::BK_CROSS: begin
        // One cross product component per cycle: two products, then subtract.
        if (k_r != 2'd3) begin
          p1_r <= da_r[i1] * db_r[i2];
          p2_r <= da_r[i2] * db_r[i1];
        end
        if (k_r != 2'd0) begin
          vec_r[k_r - 2'd1] <= {p1_r[vnac_pkg::PRD_W-1], p1_r} -
                               {p2_r[vnac_pkg::PRD_W-1], p2_r};
        end
      end
      vnac_pkg::BK_SRD: begin
        if (k_r == 2'd1) begin
          for (int i = 0; i < 3; i++) begin
            vec_r[i] <= {{(vnac_pkg::VEC_W-vnac_pkg::SUM_W){rd_sum[i][vnac_pkg::SUM_W-1]}},
                         rd_sum[i]};
          end
        end
      end
      vnac_pkg::BK_NWAIT: begin
        if (norm_done) begin
          nrm_r[0] <= n_x;
          nrm_r[1] <= n_y;
          nrm_r[2] <= n_z;
        end
      end
      vnac_pkg::BK_EMIT: begin
        if (slot_free) begin
          out_kind      <= (cmd_r.op == vnac_pkg::OP_READ) ? vnac_pkg::KIND_READ
                                                           : vnac_pkg::KIND_FACE;
          out_vertex_id <= cmd_r.id_a;
          out_norm_x    <= nrm_r[0];
          out_norm_y    <= nrm_r[1];
          out_norm_z    <= nrm_r[2];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/vertex_normal_accumulator_core.sv]
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_core
// A store is written during the back end's idle state; a clear sweeps every sum table entry to zero.
// A triangle forms the cross product of its corner edges, normalizes it and adds it to the
// three corner sums; a read normalizes one sum. A zero vector skips the normalizer's steps.
// The normalizer runs up to 29 shift steps, a 32-step root and a 3 x 18-step divide.
// One item runs at a time; the next waits until the result register is free.
// After reset the sum table is swept to zero; full stays high until the sweep ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_normal_accumulator_core #(
  parameter int MAX_VERTICES = vnac_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [1:0]                          in_func,
  input  logic [vnac_pkg::ID_W-1:0]           in_vertex_a,
  input  logic [vnac_pkg::ID_W-1:0]           in_vertex_b,
  input  logic [vnac_pkg::ID_W-1:0]           in_vertex_c,
  input  logic signed [vnac_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [vnac_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [vnac_pkg::POS_W-1:0]   in_pos_z,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic                                out_kind,
  output logic [vnac_pkg::ID_W-1:0]           out_vertex_id,
  output logic signed [vnac_pkg::NRM_W-1:0]   out_norm_x,
  output logic signed [vnac_pkg::NRM_W-1:0]   out_norm_y,
  output logic signed [vnac_pkg::NRM_W-1:0]   out_norm_z
);

  logic           q_valid;
  logic           q_pop;
  logic           init_busy;
  vnac_pkg::cmd_t q_data;

  // Front end: id checks and command queue.
  vnac_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_func     (in_func),
    .in_vertex_a (in_vertex_a),
    .in_vertex_b (in_vertex_b),
    .in_vertex_c (in_vertex_c),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .init_busy   (init_busy),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop)
  );

  // Back end: tables, arithmetic and result register.
  vnac_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_kind      (out_kind),
    .out_vertex_id (out_vertex_id),
    .out_norm_x    (out_norm_x),
    .out_norm_y    (out_norm_y),
    .out_norm_z    (out_norm_z)
  );

  // Checks on the front/back coupling.
  `ASSERT_IMP(a_pop_has_cmd, q_pop, q_valid, "command taken from an empty queue")
  `ASSERT_NXT(a_init_once, !init_busy, !init_busy, "clearing sweep restarted after reset")
  `ASSERT_IMP(a_init_blocks_in, init_busy, in_full, "input open during clearing sweep")

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Checks the vertex normal accumulator against a built-in predictor of the
// face normal, the saturating per-vertex sums and the vertex normal reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int NVERT = 1024;

  typedef struct {
    vnac_pkg::op_t   op;
    logic [10:0]     va;
    logic [10:0]     vb;
    logic [10:0]     vc;
    logic [23:0]     px;
    logic [23:0]     py;
    logic [23:0]     pz;
  } beat_in_t;

  typedef struct {
    logic            kind;
    logic [10:0]     id;
    logic [15:0]     nx;
    logic [15:0]     ny;
    logic [15:0]     nz;
  } beat_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_func = '0;
  logic [10:0] in_vertex_a = '0, in_vertex_b = '0, in_vertex_c = '0;
  logic signed [23:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_kind;
  logic [10:0] out_vertex_id;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;

  // Sampled full at the rising edge, so the driver sees the handshake result.
  logic in_full_q = 1'b1;

  vertex_normal_accumulator_core u_top (.*);

  // Predictor state.
  logic signed [23:0] pos_tab [3][NVERT];
  logic signed [23:0] sum_tab [3][NVERT];
  bit written [NVERT];

  beat_in_t  pending_beats[$];
  beat_out_t expected_normals[$];
  int error_count = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit stim_done = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Q1.15 unit vector by block shift, integer root and rounded divide.
  task automatic unit_normal(input longint v[3], output logic signed [15:0] r[3]);
    longint unsigned mag[3], m, sq, len, q;
    bit neg[3];
    m = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      r[0] = 0; r[1] = 0; r[2] = 0;
      return;
    end
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
      m <<= 1;
    end
    for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
    len = root64(sq);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 32768 + (len >> 1)) / len;
      if (q > 32767) q = 32767;
      r[i] = neg[i] ? -16'(q) : 16'(q);
    end
  endtask

  function automatic logic signed [23:0] sat_add(input logic signed [23:0] a,
                                                input logic signed [15:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    return 24'(s);
  endfunction

  function automatic bit id_valid(input logic [10:0] id);
    return id >= 1 && id <= NVERT;
  endfunction

  // Update the tables for one accepted beat and queue any expected normal.
  task automatic predict_normal(input beat_in_t b);
    longint vv[3], e1[3], e2[3];
    logic signed [15:0] n[3];
    int ix[3];
    beat_out_t r;
    case (b.op)
      vnac_pkg::OP_CLEAR: begin
        for (int a = 0; a < 3; a++)
          for (int i = 0; i < NVERT; i++) sum_tab[a][i] = '0;
      end
      vnac_pkg::OP_STORE: begin
        if (id_valid(b.va)) begin
          pos_tab[0][b.va-1] = b.px;
          pos_tab[1][b.va-1] = b.py;
          pos_tab[2][b.va-1] = b.pz;
        end
      end
      vnac_pkg::OP_READ: begin
        if (id_valid(b.va)) begin
          for (int a = 0; a < 3; a++) vv[a] = sum_tab[a][b.va-1];
          unit_normal(vv, n);
          r = '{vnac_pkg::KIND_READ, b.va, n[0], n[1], n[2]};
          expected_normals.push_back(r);
        end
      end
      default: begin
        if (id_valid(b.va) && id_valid(b.vb) && id_valid(b.vc)) begin
          ix[0] = b.va - 1; ix[1] = b.vb - 1; ix[2] = b.vc - 1;
          for (int a = 0; a < 3; a++) begin
            e1[a] = longint'(pos_tab[a][ix[0]]) - longint'(pos_tab[a][ix[1]]);
            e2[a] = longint'(pos_tab[a][ix[1]]) - longint'(pos_tab[a][ix[2]]);
          end
          vv[0] = e1[1] * e2[2] - e1[2] * e2[1];
          vv[1] = e1[2] * e2[0] - e1[0] * e2[2];
          vv[2] = e1[0] * e2[1] - e1[1] * e2[0];
          unit_normal(vv, n);
          for (int k = 0; k < 3; k++)
            for (int a = 0; a < 3; a++) sum_tab[a][ix[k]] = sat_add(sum_tab[a][ix[k]], n[a]);
          r = '{vnac_pkg::KIND_FACE, b.va, n[0], n[1], n[2]};
          expected_normals.push_back(r);
        end
      end
    endcase
  endtask

  // Driver: presents the head of the pending queue on the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full_q) begin
        // The beat went in at the last rising edge.
        void'(pending_beats.pop_front());
      end
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_push <= 1'b1;
        in_func <= pending_beats[0].op;
        in_vertex_a <= pending_beats[0].va;
        in_vertex_b <= pending_beats[0].vb;
        in_vertex_c <= pending_beats[0].vc;
        in_pos_x <= pending_beats[0].px;
        in_pos_y <= pending_beats[0].py;
        in_pos_z <= pending_beats[0].pz;
      end else begin
        in_push <= 1'b0;
      end
      out_pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Monitor: predicts on accepted input beats and checks accepted results.
  always @(posedge clk) begin
    beat_in_t b;
    beat_out_t e;
    in_full_q <= in_full;
    if (rst_n) begin
      if (in_push && !in_full) begin
        b = pending_beats[0];
        predict_normal(b);
      end
      if (out_pop && !out_empty) begin
        if (expected_normals.size() == 0) begin
          report_mismatch($sformatf("unexpected result id %0d", out_vertex_id));
        end else begin
          e = expected_normals.pop_front();
          if (out_kind !== e.kind || out_vertex_id !== e.id || out_norm_x !== e.nx ||
              out_norm_y !== e.ny || out_norm_z !== e.nz)
            report_mismatch($sformatf(
              "got k%0d id%0d (%0d %0d %0d) want k%0d id%0d (%0d %0d %0d)",
              out_kind, out_vertex_id, out_norm_x, out_norm_y, out_norm_z,
              e.kind, e.id, $signed(e.nx), $signed(e.ny), $signed(e.nz)));
        end
      end
    end
  end

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 8191)) - 24'd4096;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [10:0] rand_id(input int hi);
    int p;
    p = $urandom_range(99);
    if (p < 2) return 11'd0;
    if (p < 4) return 11'($urandom_range(NVERT + 1, 2047));
    if (p < 6) return 11'(NVERT);
    return 11'($urandom_range(1, hi));
  endfunction

  task automatic queue_beat(input vnac_pkg::op_t op, input logic [10:0] a, b, c,
                            input logic [23:0] x, y, z);
    beat_in_t t;
    t = '{op, a, b, c, x, y, z};
    // Never let a triangle touch a vertex that has not been stored.
    if (op == vnac_pkg::OP_STORE && id_valid(a)) written[a-1] = 1;
    pending_beats.push_back(t);
  endtask

  function automatic bit corners_ready(input logic [10:0] a, b, c);
    return (!id_valid(a) || written[a-1]) && (!id_valid(b) || written[b-1]) &&
           (!id_valid(c) || written[c-1]);
  endfunction

  task automatic wait_drained();
    while (pending_beats.size() > 0 || expected_normals.size() > 0) @(posedge clk);
    repeat (NVERT + 300) @(posedge clk);
  endtask

  // Stimulus: directed corners, then random phases with varied idling.
  initial begin
    logic [10:0] a, b, c;
    int hi;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extreme positions, degenerate and bad-id triangles.
    queue_beat(vnac_pkg::OP_STORE, 1, 0, 0, 24'h000000, 24'h000000, 24'h000000);
    queue_beat(vnac_pkg::OP_STORE, 2, 0, 0, 24'h7fffff, 24'h000000, 24'h000000);
    queue_beat(vnac_pkg::OP_STORE, 3, 0, 0, 24'h000000, 24'h7fffff, 24'h000000);
    queue_beat(vnac_pkg::OP_STORE, 11'(NVERT), 0, 0, 24'h800000, 24'h800000, 24'h800000);
    queue_beat(vnac_pkg::OP_STORE, 4, 0, 0, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    queue_beat(vnac_pkg::OP_STORE, 0, 0, 0, 24'h123456, 24'h654321, 24'h0);
    queue_beat(vnac_pkg::OP_STORE, 11'h7ff, 0, 0, 24'hffffff, 24'hffffff, 24'hffffff);
    queue_beat(vnac_pkg::OP_READ, 1, 0, 0, 0, 0, 0);
    queue_beat(vnac_pkg::OP_TRI, 1, 2, 3, 0, 0, 0);
    queue_beat(vnac_pkg::OP_TRI, 2, 3, 11'(NVERT), 0, 0, 0);
    queue_beat(vnac_pkg::OP_TRI, 1, 1, 2, 0, 0, 0);
    queue_beat(vnac_pkg::OP_TRI, 1, 4, 11'(NVERT), 0, 0, 0);
    queue_beat(vnac_pkg::OP_TRI, 0, 2, 3, 0, 0, 0);
    queue_beat(vnac_pkg::OP_TRI, 1, 11'h7ff, 3, 0, 0, 0);
    queue_beat(vnac_pkg::OP_TRI, 1, 2, 11'(NVERT + 1), 0, 0, 0);
    queue_beat(vnac_pkg::OP_READ, 2, 0, 0, 0, 0, 0);
    queue_beat(vnac_pkg::OP_READ, 11'(NVERT), 0, 0, 0, 0, 0);
    queue_beat(vnac_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    queue_beat(vnac_pkg::OP_READ, 11'h7ff, 0, 0, 0, 0, 0);
    for (int i = 0; i < 3; i++) queue_beat(vnac_pkg::OP_TRI, 2, 3, 4, 0, 0, 0);
    queue_beat(vnac_pkg::OP_READ, 3, 0, 0, 0, 0, 0);
    queue_beat(vnac_pkg::OP_CLEAR, 11'h7ff, 11'h7ff, 11'h7ff,
               24'hffffff, 24'hffffff, 24'hffffff);
    queue_beat(vnac_pkg::OP_READ, 3, 0, 0, 0, 0, 0);
    wait_drained();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 80 : (ph == 3) ? 37 : 0;
      recv_stall = (ph == 2) ? 80 : (ph == 3) ? 37 : 0;
      for (int n = 0; n < 420; n++) begin
        // Small id range most of the time so sums build up and saturate.
        hi = ($urandom_range(3) == 0) ? NVERT : 8;
        case ($urandom_range(99)) inside
          [0:1]: queue_beat(vnac_pkg::OP_CLEAR, 11'($urandom), 11'($urandom),
                            11'($urandom), rand_coord(), rand_coord(), rand_coord());
          [2:35]: queue_beat(vnac_pkg::OP_STORE, rand_id(hi), 11'($urandom),
                             11'($urandom), rand_coord(), rand_coord(), rand_coord());
          [36:75]: begin
            a = rand_id(hi); b = rand_id(hi); c = rand_id(hi);
            if (!corners_ready(a, b, c)) begin
              a = 1; b = 2; c = 3;
            end
            queue_beat(vnac_pkg::OP_TRI, a, b, c, rand_coord(), rand_coord(), rand_coord());
          end
          default: queue_beat(vnac_pkg::OP_READ, rand_id(hi), 11'($urandom),
                              11'($urandom), rand_coord(), rand_coord(), rand_coord());
        endcase
        if (pending_beats.size() > 16) wait (pending_beats.size() < 4);
      end
      wait_drained();
    end
    stim_done = 1;
  end

  // Final verdict once all stimulus has drained.
  initial begin
    wait (stim_done);
    if (error_count == 0 && expected_normals.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(64'd60_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
